FILE: rtl/core/cip_pkg.sv
package cip_pkg;

    localparam int STORE_SIDE_DEFAULT = 64;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 7;
    localparam int SIZE_W      = 7;

    localparam int ADDR_W      = 10;
    localparam int CHAN_W      = 8;
    localparam int CODE_W      = 2;

    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 24;

    localparam logic [CHAN_W-1:0] ALPHA_LIMIT = 8'd128;
    localparam logic [9:0]        BRIGHT_SUM  = 10'd387;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SOURCE_FORMAT = 2'd0,
        CFG_IMAGE_WIDTH   = 2'd1,
        CFG_IMAGE_HEIGHT  = 2'd2
    } cfg_index_t;

    typedef enum logic {
        FMT_MASK = 1'b0,
        FMT_ARGB = 1'b1
    } source_format_t;

    typedef enum logic [CODE_W-1:0] {
        CODE_TRANSPARENT = 2'd0,
        CODE_LIGHT       = 2'd1,
        CODE_DARK        = 2'd2
    } pixel_code_t;

    typedef struct packed {
        logic              and_bit;
        logic              xor_bit;
        logic [CHAN_W-1:0] alpha;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

endpackage

FILE: rtl/core/cursor_image_2bpp_packer_unit.sv
// Cursor image packer: source pixels in, 2-bit-per-pixel cursor store bytes out.
// s_* channel: one pixel word per handshake, raster order, rows of image_width
//   pixels, image_height rows. No framing is needed; the block counts.
// m_* channel: one word per four pixels of a row and one at each row end,
//   carrying the store byte offset and the packed byte; m_tlast marks the
//   byte that holds the final pixel of the image. Partial bytes are zero-padded.
// cfg_* channel: register writes (0 source format, 1 width, 2 height), always
//   ready. Any write to a known register restarts the image at row 0, column 0.
//   Write only while no pixel is in flight.
// A pixel and its byte (if any) pass through one input register, then the
//   mapping and packing logic, then the output register. Throughput: one
//   pixel per cycle, as long as m_tready keeps up.
// When the receiver stalls, the output word holds and s_tready drops once the
//   input register is also full; nothing is lost or repeated.
// Reset (aresetn low, synchronous) empties both registers, clears counters and
//   the packing byte, and restores mask format with a 64 x 64 image size.
module cursor_image_2bpp_packer_unit
    import cip_pkg::*;
#(
    parameter int STORE_SIDE = STORE_SIDE_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    // and_bit, xor_bit, alpha[7:0], red[7:0], green[7:0], blue[7:0], zero pad
    input  logic [S_TDATA_W-1:0]   s_tdata,

    output logic                   m_tvalid,
    input  logic                   m_tready,
    // byte_address[9:0], byte_value[7:0], zero pad
    output logic [M_TDATA_W-1:0]   m_tdata,
    output logic                   m_tlast,   // image_done

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int CNT_W     = $clog2(STORE_SIDE);
    localparam int SIDE_W    = $clog2(STORE_SIDE + 1);
    localparam int CMP_W     = (SIDE_W > SIZE_W) ? SIDE_W : SIZE_W;
    localparam int ROW_BYTES = STORE_SIDE / 4;
    localparam int PROD_W    = CNT_W + $clog2(ROW_BYTES + 1);
    localparam int SUM_W     = (PROD_W + 1 > ADDR_W) ? PROD_W + 1 : ADDR_W;

    // configuration
    source_format_t    source_format_reg;
    logic [SIZE_W-1:0] image_width_reg;
    logic [SIZE_W-1:0] image_height_reg;
    logic              cfg_write;
    logic              cfg_known;

    // input stage
    logic              in_valid_reg;
    pixel_t            in_pixel_reg;

    // image position and packing
    logic [CNT_W-1:0]  column_count_reg, column_count_next;
    logic [CNT_W-1:0]  row_count_reg, row_count_next;
    logic [7:0]        pack_acc_reg, pack_acc_next;

    // output stage
    logic              m_valid_reg, m_valid_next;
    logic [ADDR_W-1:0] m_addr_reg;
    logic [7:0]        m_byte_reg;
    logic              m_done_reg;

    logic              out_free;
    logic              step;
    logic [CODE_W-1:0] code;
    logic [SIDE_W-1:0] width_eff;
    logic [SIDE_W-1:0] height_eff;
    logic [CNT_W-1:0]  col;
    logic [CNT_W-1:0]  row;
    logic [7:0]        acc_merged;
    logic              row_end;
    logic              last_pixel;
    logic              emit;
    logic [SUM_W-1:0]  addr_full;

    function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIZE_W-1:0] v);
        logic [SIDE_W-1:0] r;
        if (v == '0) begin
            r = SIDE_W'(1);
        end else if (CMP_W'(v) > CMP_W'(STORE_SIDE)) begin
            r = SIDE_W'(STORE_SIDE);
        end else begin
            r = SIDE_W'(v);
        end
        return r;
    endfunction

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign cfg_known = (cfg_index == CFG_SOURCE_FORMAT) || (cfg_index == CFG_IMAGE_WIDTH)
                    || (cfg_index == CFG_IMAGE_HEIGHT);

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || out_free;
    assign step     = in_valid_reg && out_free;

    cip_pixel_map u_pixel_map (
        .source_format (source_format_reg),
        .pixel         (in_pixel_reg),
        .code          (code)
    );

    always_comb begin
        width_eff  = clamp_side(image_width_reg);
        height_eff = clamp_side(image_height_reg);

        // keep the position inside the image
        col = ((CNT_W + 1)'(column_count_reg) >= (CNT_W + 1)'(width_eff))
            ? '0 : column_count_reg;
        row = ((CNT_W + 1)'(row_count_reg) >= (CNT_W + 1)'(height_eff))
            ? '0 : row_count_reg;

        acc_merged = pack_acc_reg | (8'(code) << {col[1:0], 1'b0});
        row_end    = ((CNT_W + 1)'(col) + (CNT_W + 1)'(1)) == (CNT_W + 1)'(width_eff);
        last_pixel = row_end
                  && (((CNT_W + 1)'(row) + (CNT_W + 1)'(1)) == (CNT_W + 1)'(height_eff));
        emit       = (col[1:0] == 2'b11) || row_end;
        addr_full  = SUM_W'(row) * SUM_W'(ROW_BYTES) + SUM_W'(col >> 2);

        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        pack_acc_next     = pack_acc_reg;
        m_valid_next      = m_valid_reg && !m_tready;

        if (cfg_write && cfg_known) begin
            column_count_next = '0;
            row_count_next    = '0;
            pack_acc_next     = '0;
        end else if (step) begin
            pack_acc_next = emit ? 8'd0 : acc_merged;
            m_valid_next  = emit;
            if (row_end) begin
                column_count_next = '0;
                row_count_next    = last_pixel ? '0 : CNT_W'(row + CNT_W'(1));
            end else begin
                column_count_next = CNT_W'(col + CNT_W'(1));
                row_count_next    = row;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_format_reg <= FMT_MASK;
            image_width_reg   <= SIZE_W'(64);
            image_height_reg  <= SIZE_W'(64);
        end else if (cfg_write) begin
            case (cfg_index)
                CFG_SOURCE_FORMAT: source_format_reg <= source_format_t'(cfg_data[0]);
                CFG_IMAGE_WIDTH:   image_width_reg   <= cfg_data;
                CFG_IMAGE_HEIGHT:  image_height_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
            column_count_reg <= '0;
            row_count_reg    <= '0;
            pack_acc_reg     <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            m_valid_reg      <= m_valid_next;
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            pack_acc_reg     <= pack_acc_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_pixel_reg.and_bit <= s_tdata[0];
            in_pixel_reg.xor_bit <= s_tdata[1];
            in_pixel_reg.alpha   <= s_tdata[9:2];
            in_pixel_reg.red     <= s_tdata[17:10];
            in_pixel_reg.green   <= s_tdata[25:18];
            in_pixel_reg.blue    <= s_tdata[33:26];
        end
        if (step && emit) begin
            m_addr_reg <= addr_full[ADDR_W-1:0];
            m_byte_reg <= acc_merged;
            m_done_reg <= last_pixel;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_byte_reg, m_addr_reg};
    assign m_tlast  = m_done_reg;

endmodule

FILE: rtl/core/cip_pixel_map.sv
module cip_pixel_map
    import cip_pkg::*;
(
    input  source_format_t    source_format,
    input  pixel_t            pixel,
    output logic [CODE_W-1:0] code
);

    logic [9:0] rgb_sum;

    assign rgb_sum = 10'(pixel.red) + 10'(pixel.green) + 10'(pixel.blue);

    always_comb begin
        case (source_format)
            FMT_MASK: begin
                if (!pixel.and_bit) begin
                    code = pixel.xor_bit ? CODE_LIGHT : CODE_DARK;
                end else begin
                    code = pixel.xor_bit ? CODE_DARK : CODE_TRANSPARENT;
                end
            end
            FMT_ARGB: begin
                // at or below half alpha the pixel is see-through
                if (pixel.alpha <= ALPHA_LIMIT) begin
                    code = CODE_TRANSPARENT;
                end else if (rgb_sum >= BRIGHT_SUM) begin
                    code = CODE_LIGHT;
                end else begin
                    code = CODE_DARK;
                end
            end
            default: code = CODE_TRANSPARENT;
        endcase
    end

endmodule

FILE: rtl/core/cip_checker.sv
module cip_checker
    import cip_pkg::*;
#(
    parameter int STORE_SIDE = STORE_SIDE_DEFAULT
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast
);

    localparam int ROW_BYTES = STORE_SIDE / 4;

    logic after_last_reg;

    // remember whether the last word taken closed an image
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            after_last_reg <= 1'b1;
        end else if (m_tvalid && m_tready) begin
            after_last_reg <= m_tlast;
        end
    end

    // hold a stalled word
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    // no pixel code is ever the unused value
    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[11:10] != 2'b11) && (m_tdata[13:12] != 2'b11)
                  && (m_tdata[15:14] != 2'b11) && (m_tdata[17:16] != 2'b11))
        else $error("packed byte holds an invalid code");

    a_new_image_row0: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && after_last_reg |-> m_tdata[ADDR_W-1:0] < ADDR_W'(ROW_BYTES))
        else $error("first byte of an image is not in row zero");

    a_drain_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output");

endmodule

bind cursor_image_2bpp_packer_unit cip_checker #(
    .STORE_SIDE (STORE_SIDE)
) u_cip_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
